// File: hdl/qstu_pkg.sv
// ----------------------------------------------------------------------------
// qstu_pkg: shared types and constants for the smallest-three unpacker
// Record layout widths, the square-root cell payload and the Q.24 constant for 1.0 squared.
// ----------------------------------------------------------------------------
`default_nettype none

package qstu_pkg;

  // Stored component width and output component width (Q.12)
  localparam int unsigned COMP_W  = 12;
  localparam int unsigned OUT_W   = 14;
  localparam int unsigned IDX_W   = 2;

  // Squares, sum and radicand widths
  localparam int unsigned SQ_W    = 23;
  localparam int unsigned SUM_W   = 25;
  localparam int unsigned RAD_W   = 26;
  localparam int unsigned ROOT_W  = 13;
  localparam int unsigned REM_W   = 14;

  // One root bit per cell
  localparam int unsigned NUM_CELLS = 13;

  // 1.0 squared in Q.24
  localparam logic [SUM_W-1:0] ONE_SQ = 25'h100_0000;

  // Unpacked record fields
  typedef struct packed {
    logic [COMP_W-1:0] c0;
    logic [COMP_W-1:0] c1;
    logic [COMP_W-1:0] c2;
    logic [IDX_W-1:0]  drop;
  } rec_t;

  // Payload handed from cell to cell
  typedef struct packed {
    rec_t              rec;
    logic [RAD_W-1:0]  rad;
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
  } cell_t;

endpackage : qstu_pkg

`default_nettype wire

// File: hdl/quaternion_smallest_three_unpack.sv
// ----------------------------------------------------------------------------
// Pipeline: an accepted record passes 2 front stages, then 13 square-root
//   cells, the last of which is the output reg, before its result beat.
// Throughput: one record per cycle; a stalled output holds only its own cell,
//   bubbles further up keep filling until the chain is full.
// Reset: asynchronous, active low; clears all stage valid bits.
// ----------------------------------------------------------------------------
// quaternion_smallest_three_unpack: smallest-three quaternion record decoder
// Unpacks three Q.12 components and rebuilds the dropped one as an integer
// square root through a chain of one-bit cells.
// ----------------------------------------------------------------------------
`default_nettype none

module quaternion_smallest_three_unpack (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  output logic                                in_stall_o,
  input  wire logic [7:0]                     byte0_i,
  input  wire logic [7:0]                     byte1_i,
  input  wire logic [7:0]                     byte2_i,
  input  wire logic [7:0]                     byte3_i,
  input  wire logic [7:0]                     byte4_i,
  output logic                                out_valid_o,
  input  wire logic                           out_stall_i,
  output logic signed [qstu_pkg::OUT_W-1:0]   comp0_o,
  output logic signed [qstu_pkg::OUT_W-1:0]   comp1_o,
  output logic signed [qstu_pkg::OUT_W-1:0]   comp2_o,
  output logic signed [qstu_pkg::OUT_W-1:0]   comp3_o,
  output logic [qstu_pkg::IDX_W-1:0]          dropped_index_o
);

  logic                       front_ready_w;
  logic                       valid_w [qstu_pkg::NUM_CELLS+1];
  logic                       ready_w [qstu_pkg::NUM_CELLS+1];
  qstu_pkg::cell_t            cell_w  [qstu_pkg::NUM_CELLS+1];
  logic [qstu_pkg::NUM_CELLS:0] busy_w;

  qstu_pkg::cell_t            last_w;
  logic [qstu_pkg::OUT_W-1:0] root_x_w;
  logic [qstu_pkg::OUT_W-1:0] s0_w, s1_w, s2_w;

  // Front end: unpack, square, radicand
  qstu_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .ready_o (front_ready_w),
    .byte0_i (byte0_i),
    .byte1_i (byte1_i),
    .byte2_i (byte2_i),
    .byte3_i (byte3_i),
    .byte4_i (byte4_i),
    .ready_i (ready_w[0]),
    .valid_o (valid_w[0]),
    .cell_o  (cell_w[0])
  );

  assign in_stall_o = !front_ready_w;

  // Square-root cell chain, one root bit per cell
  for (genvar g = 0; g < qstu_pkg::NUM_CELLS; g++) begin : g_cell
    qstu_sqrt_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (valid_w[g]),
      .ready_o (ready_w[g]),
      .cell_i  (cell_w[g]),
      .ready_i (ready_w[g+1]),
      .valid_o (valid_w[g+1]),
      .cell_o  (cell_w[g+1])
    );
    assign busy_w[g] = valid_w[g+1];
  end

  assign ready_w[qstu_pkg::NUM_CELLS] = !out_stall_i;
  assign busy_w[qstu_pkg::NUM_CELLS]  = valid_w[0];

  // Result beat: place stored components around the rebuilt one
  assign last_w   = cell_w[qstu_pkg::NUM_CELLS];
  assign root_x_w = {1'b0, last_w.root};
  assign s0_w = {{(qstu_pkg::OUT_W-qstu_pkg::COMP_W){last_w.rec.c0[qstu_pkg::COMP_W-1]}},
                 last_w.rec.c0};
  assign s1_w = {{(qstu_pkg::OUT_W-qstu_pkg::COMP_W){last_w.rec.c1[qstu_pkg::COMP_W-1]}},
                 last_w.rec.c1};
  assign s2_w = {{(qstu_pkg::OUT_W-qstu_pkg::COMP_W){last_w.rec.c2[qstu_pkg::COMP_W-1]}},
                 last_w.rec.c2};

  always_comb begin
    unique case (last_w.rec.drop)
      2'd0: begin
        comp0_o = root_x_w; comp1_o = s0_w; comp2_o = s1_w; comp3_o = s2_w;
      end
      2'd1: begin
        comp0_o = s0_w; comp1_o = root_x_w; comp2_o = s1_w; comp3_o = s2_w;
      end
      2'd2: begin
        comp0_o = s0_w; comp1_o = s1_w; comp2_o = root_x_w; comp3_o = s2_w;
      end
      default: begin
        comp0_o = s0_w; comp1_o = s1_w; comp2_o = s2_w; comp3_o = root_x_w;
      end
    endcase
  end

  assign dropped_index_o = last_w.rec.drop;
  assign out_valid_o     = valid_w[qstu_pkg::NUM_CELLS];

`ifndef SYNTHESIS
  // Input is held off only when the front and every cell hold a beat
  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (&busy_w))
    else $error("input stalled with a bubble in the chain");

  // Rebuilt component never exceeds 1.0 in Q.12
  a_root_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (last_w.root <= 13'd4096))
    else $error("rebuilt component out of range");

  // Remainder after the last step stays within 2*root
  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ({1'b0, last_w.rem} <= {1'b0, last_w.root, 1'b0}))
    else $error("square-root remainder too large");

  // A stalled output beat is not overwritten by the cell behind it
  a_hold_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(last_w)))
    else $error("output beat changed under stall");
`endif

endmodule : quaternion_smallest_three_unpack

`default_nettype wire

// File: hdl/qstu_front.sv
// ----------------------------------------------------------------------------
// qstu_front: record unpack, squaring and radicand stages
// Two pipeline stages: unpack and square, then sum and subtract from 1.0^2.
// ----------------------------------------------------------------------------
`default_nettype none

module qstu_front (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  valid_i,
  output logic                       ready_o,
  input  wire logic [7:0]            byte0_i,
  input  wire logic [7:0]            byte1_i,
  input  wire logic [7:0]            byte2_i,
  input  wire logic [7:0]            byte3_i,
  input  wire logic [7:0]            byte4_i,
  input  wire logic                  ready_i,
  output logic                       valid_o,
  output qstu_pkg::cell_t            cell_o
);

  qstu_pkg::rec_t                    rec_w;
  logic signed [2*qstu_pkg::COMP_W-1:0] p0_w, p1_w, p2_w;

  logic                              va_q;
  qstu_pkg::rec_t                    reca_q;
  logic [qstu_pkg::SQ_W-1:0]         sq0_q, sq1_q, sq2_q;
  logic                              ready_a_w;

  logic                              vb_q;
  qstu_pkg::cell_t                   cellb_q;
  logic [qstu_pkg::SUM_W-1:0]        sum_w;

  // Unpack the 5-byte record
  always_comb begin
    rec_w.c0   = {byte4_i[3:0], byte3_i};
    rec_w.c1   = {byte2_i, byte1_i[7:4]};
    rec_w.c2   = {byte1_i[3:0], byte0_i};
    rec_w.drop = byte4_i[7:6];
  end

  // Squares of the stored components (at most 2^22)
  assign p0_w = $signed(rec_w.c0) * $signed(rec_w.c0);
  assign p1_w = $signed(rec_w.c1) * $signed(rec_w.c1);
  assign p2_w = $signed(rec_w.c2) * $signed(rec_w.c2);

  // Stage A handshake
  assign ready_o   = !va_q || ready_a_w;
  assign ready_a_w = !vb_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
    end else if (ready_o) begin
      va_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      reca_q <= rec_w;
      sq0_q  <= p0_w[qstu_pkg::SQ_W-1:0];
      sq1_q  <= p1_w[qstu_pkg::SQ_W-1:0];
      sq2_q  <= p2_w[qstu_pkg::SQ_W-1:0];
    end
  end

  // Sum of squares, always below 2^24
  assign sum_w = {2'b00, sq0_q} + {2'b00, sq1_q} + {2'b00, sq2_q};

  // Stage B: radicand into the first cell's payload
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vb_q <= 1'b0;
    end else if (ready_a_w) begin
      vb_q <= va_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_a_w && va_q) begin
      cellb_q.rec  <= reca_q;
      cellb_q.rad  <= {1'b0, qstu_pkg::ONE_SQ - sum_w};
      cellb_q.rem  <= '0;
      cellb_q.root <= '0;
    end
  end

  assign valid_o = vb_q;
  assign cell_o  = cellb_q;

endmodule : qstu_front

`default_nettype wire

// File: hdl/qstu_sqrt_cell.sv
// ----------------------------------------------------------------------------
// qstu_sqrt_cell: one restoring square-root step
// Takes the next two radicand bits, tries root bit one, keeps it if it fits.
// ----------------------------------------------------------------------------
`default_nettype none

module qstu_sqrt_cell (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             valid_i,
  output logic                  ready_o,
  input  wire qstu_pkg::cell_t  cell_i,
  input  wire logic             ready_i,
  output logic                  valid_o,
  output qstu_pkg::cell_t       cell_o
);

  logic                         valid_q;
  qstu_pkg::cell_t              cell_q;
  qstu_pkg::cell_t              cell_d;
  logic [qstu_pkg::REM_W+1:0]   acc_w;
  logic [qstu_pkg::REM_W+1:0]   trial_w;
  logic [qstu_pkg::REM_W+1:0]   diff_w;

  // Trial subtract of 4*root+1 from the shifted remainder
  always_comb begin
    acc_w   = {cell_i.rem, cell_i.rad[qstu_pkg::RAD_W-1 -: 2]};
    trial_w = {1'b0, cell_i.root, 2'b01};
    diff_w  = acc_w - trial_w;
    cell_d      = cell_i;
    cell_d.rad  = {cell_i.rad[qstu_pkg::RAD_W-3:0], 2'b00};
    if (acc_w >= trial_w) begin
      cell_d.rem  = diff_w[qstu_pkg::REM_W-1:0];
      cell_d.root = {cell_i.root[qstu_pkg::ROOT_W-2:0], 1'b1};
    end else begin
      cell_d.rem  = acc_w[qstu_pkg::REM_W-1:0];
      cell_d.root = {cell_i.root[qstu_pkg::ROOT_W-2:0], 1'b0};
    end
  end

  // Beat moves on when this cell is empty or the next one takes its beat
  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      cell_q <= cell_d;
    end
  end

  assign valid_o = valid_q;
  assign cell_o  = cell_q;

endmodule : qstu_sqrt_cell

`default_nettype wire
